### rtl/core/int64_decimal_text_appender_assert.svh
// Assertion macros for the decimal text appender
`ifndef INT64_DECIMAL_TEXT_APPENDER_ASSERT_SVH
`define INT64_DECIMAL_TEXT_APPENDER_ASSERT_SVH

`ifndef ASSERT_OFF
`define I64DTA_ASSERT_IMP(lbl, pre, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
        else $error("i64dta assertion failed");
`define I64DTA_ASSERT_NEXT(lbl, pre, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
        else $error("i64dta assertion failed");
`else
`define I64DTA_ASSERT_IMP(lbl, pre, con)
`define I64DTA_ASSERT_NEXT(lbl, pre, con)
`endif

`endif

### rtl/core/i64dta_pkg.sv
package i64dta_pkg;

    localparam int VALUE_BITS          = 64;
    localparam int DIGIT_COUNT         = 20;
    localparam int BCD_BITS            = 4 * DIGIT_COUNT;
    localparam int BIT_CNT_BITS        = $clog2(VALUE_BITS);
    localparam int DIGIT_CNT_BITS      = $clog2(DIGIT_COUNT + 1);
    localparam int SPACE_NEEDED        = 21;
    localparam int CAP_BITS            = 16;
    localparam int OUT_DATA_BITS       = 40;
    localparam int LENGTH_BITS_DEFAULT = 16;

    localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 16'd4096;
    localparam logic [7:0]          CHAR_ZERO      = 8'd48;
    localparam logic [7:0]          CHAR_MINUS     = 8'd45;
    localparam logic [7:0]          CHAR_NONE      = 8'd0;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [0:0] REG_BUFFER_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT,
        ST_RESULT
    } state_t;

endpackage

### rtl/core/int64_decimal_text_appender.sv
// Decimal text appender for signed 64-bit values.
// Input stream: s_tdata carries the value, s_tuser selects append or clear.
// Output stream: one transaction per character, tlast on the final one of
// an item; tuser flags whether the item was accepted.
// APB port at byte address 0 holds the buffer capacity (reset 4096).
// An append converts through a bit-serial double-dabble register, one
// magnitude bit per cycle, then drops leading zero digits one at a time
// (up to 19), then emits one character per cycle while the receiver
// accepts. A refused append or a clear moves to the result state, which
// gives its single result through the output register once it is free.
// Items are taken one at a time; s_tready is high only while no item is
// in work. A held output register lets the next item enter while the last
// result still waits. When the receiver stalls, character emission pauses
// and the register holds its transaction. Reset empties the output, clears
// the fill length to zero and restores the capacity to 4096. There is no
// clearing pass; the block is ready as soon as reset is released.
`include "int64_decimal_text_appender_assert.svh"

module int64_decimal_text_appender
    import i64dta_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [VALUE_BITS-1:0]    s_tdata,   // number_value[63:0]
    input  logic [0:0]               s_tuser,   // opcode[0]
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,   // text_byte[7:0], byte_offset[23:8],
                                                // fill_length[39:24]
    output logic [0:0]               m_tuser,   // accepted[0]
    output logic                     m_tlast,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int LW = (LENGTH_BITS > CAP_BITS) ? LENGTH_BITS : CAP_BITS;
    localparam int CW = LW + 1;

    state_t state_reg, state_next;

    logic [LENGTH_BITS-1:0]    used_reg, used_next;
    logic [CAP_BITS-1:0]       cap_reg, cap_next;
    logic                      out_valid_reg, out_valid_next;
    logic [OUT_DATA_BITS-1:0]  out_data_reg, out_data_next;
    logic                      out_user_reg, out_user_next;
    logic                      out_last_reg, out_last_next;
    logic [BCD_BITS-1:0]       bcd_reg, bcd_next;
    logic [VALUE_BITS-1:0]     bin_reg, bin_next;
    logic [BIT_CNT_BITS-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIGIT_CNT_BITS-1:0] digit_cnt_reg, digit_cnt_next;
    logic                      neg_reg, neg_next;
    logic                      clear_reg, clear_next;

    logic [BCD_BITS-1:0]    bcd_adj;
    logic [3:0]             top_digit;
    logic [VALUE_BITS-1:0]  magnitude;
    logic [LENGTH_BITS-1:0] used_inc;
    logic [CW-1:0]          used_ext;
    logic [CW-1:0]          inc_ext;
    logic [CW-1:0]          cap_ext;
    logic                   refused;
    logic                   slot_free;
    logic                   cfg_write;
    logic [0:0]             reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_index)
            REG_BUFFER_CAPACITY: prdata = {{(32-CAP_BITS){1'b0}}, cap_reg};
            default:             prdata = '0;
        endcase
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;
    assign m_tlast   = out_last_reg;
    assign slot_free = !out_valid_reg || m_tready;

    assign used_inc  = used_reg + LENGTH_BITS'(1);
    assign used_ext  = CW'(used_reg);
    assign inc_ext   = CW'(used_inc);
    assign cap_ext   = CW'(cap_reg);
    assign refused   = (used_ext > cap_ext) || ((used_ext + CW'(SPACE_NEEDED)) > cap_ext);
    assign magnitude = s_tdata[VALUE_BITS-1] ? (~s_tdata + VALUE_BITS'(1)) : s_tdata;
    assign top_digit = bcd_reg[BCD_BITS-1 -: 4];

    always_comb
    begin
        logic [3:0] d;
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            d = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0] == OP_CLEAR || refused)
                        state_next = ST_RESULT;
                    else
                        state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (bit_cnt_reg == '0)
                    state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                if (!(top_digit == 4'd0 && digit_cnt_reg > DIGIT_CNT_BITS'(1)))
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN:
            begin
                if (slot_free)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free && digit_cnt_reg == DIGIT_CNT_BITS'(1))
                    state_next = ST_IDLE;
            end
            ST_RESULT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        used_next      = used_reg;
        cap_next       = cap_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        bcd_next       = bcd_reg;
        bin_next       = bin_reg;
        bit_cnt_next   = bit_cnt_reg;
        digit_cnt_next = digit_cnt_reg;
        neg_next       = neg_reg;
        clear_next     = clear_reg;

        if (cfg_write && reg_index == REG_BUFFER_CAPACITY)
            cap_next = pwdata[CAP_BITS-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    clear_next     = (s_tuser[0] == OP_CLEAR);
                    neg_next       = s_tdata[VALUE_BITS-1];
                    bin_next       = magnitude;
                    bcd_next       = '0;
                    bit_cnt_next   = BIT_CNT_BITS'(VALUE_BITS - 1);
                    digit_cnt_next = DIGIT_CNT_BITS'(DIGIT_COUNT);
                end
            end
            ST_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_BITS-2:0], bin_reg[VALUE_BITS-1]};
                bin_next     = {bin_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BIT_CNT_BITS'(1);
            end
            ST_SKIP:
            begin
                // drop leading zero digits, keep at least one
                if (top_digit == 4'd0 && digit_cnt_reg > DIGIT_CNT_BITS'(1))
                begin
                    bcd_next       = {bcd_reg[BCD_BITS-5:0], 4'd0};
                    digit_cnt_next = digit_cnt_reg - DIGIT_CNT_BITS'(1);
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {inc_ext[15:0], used_ext[15:0], CHAR_MINUS};
                    out_user_next  = 1'b1;
                    out_last_next  = 1'b0;
                    used_next      = used_inc;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {inc_ext[15:0], used_ext[15:0],
                                      CHAR_ZERO + {4'd0, top_digit}};
                    out_user_next  = 1'b1;
                    out_last_next  = (digit_cnt_reg == DIGIT_CNT_BITS'(1));
                    used_next      = used_inc;
                    bcd_next       = {bcd_reg[BCD_BITS-5:0], 4'd0};
                    digit_cnt_next = digit_cnt_reg - DIGIT_CNT_BITS'(1);
                end
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (clear_reg)
                    begin
                        out_data_next = {16'd0, 16'd0, CHAR_NONE};
                        out_user_next = 1'b1;
                        used_next     = '0;
                    end
                    else
                    begin
                        out_data_next = {used_ext[15:0], used_ext[15:0], CHAR_NONE};
                        out_user_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            cap_reg       <= CAPACITY_RESET;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            digit_cnt_reg <= '0;
            neg_reg       <= 1'b0;
            clear_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            digit_cnt_reg <= digit_cnt_next;
            neg_reg       <= neg_next;
            clear_reg     <= clear_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
        bcd_reg      <= bcd_next;
        bin_reg      <= bin_next;
    end

    `I64DTA_ASSERT_NEXT(a_conv_runs, state_reg == ST_CONV && bit_cnt_reg != '0, state_reg == ST_CONV)
    `I64DTA_ASSERT_IMP(a_emit_count, state_reg == ST_EMIT || state_reg == ST_SIGN, digit_cnt_reg != '0)
    `I64DTA_ASSERT_IMP(a_refused_last, m_tvalid && m_tuser[0] == 1'b0, m_tlast && m_tdata[7:0] == CHAR_NONE)
    `I64DTA_ASSERT_IMP(a_busy_no_ready, state_reg != ST_IDLE, !s_tready)

endmodule

### verif/decimal_text_checker.sv
module decimal_text_checker
    import i64dta_pkg::*;
#(
    parameter int LEN_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [VALUE_BITS-1:0]    s_tdata,
    input  logic [0:0]               s_tuser,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [OUT_DATA_BITS-1:0] m_tdata,
    input  logic [0:0]               m_tuser,
    input  logic                     m_tlast,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output int                       mismatches,
    output int                       in_flight,
    output int                       items_seen,
    output int                       results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RADIX = 10;

    typedef struct {
        logic [7:0]  text_byte;
        logic [15:0] byte_offset;
        logic        accepted;
        logic        last_of_run;
        logic [15:0] fill_length;
    } char_txn_t;

    char_txn_t           expected_chars[$];
    logic [CAP_BITS-1:0] capacity = CAPACITY_RESET;
    logic [LEN_BITS-1:0] used_len = '0;
    int                  err_count = 0;
    int                  pending_count = 0;
    int                  item_count = 0;
    int                  char_count = 0;

    assign mismatches   = err_count;
    assign in_flight    = pending_count;
    assign items_seen   = item_count;
    assign results_seen = char_count;

    function automatic void queue_char(logic [7:0] ch, logic [15:0] off, logic acc,
                                       logic last, logic [15:0] fill);
        char_txn_t t;
        t.text_byte   = ch;
        t.byte_offset = off;
        t.accepted    = acc;
        t.last_of_run = last;
        t.fill_length = fill;
        expected_chars.push_back(t);
    endfunction

    function automatic void predict_text(logic op, logic [63:0] value);
        logic [63:0]         mag;
        logic [7:0]          text[$];
        logic                neg;
        logic [LEN_BITS-1:0] off;
        neg = value[63];
        mag = neg ? -value : value;
        if (op == OP_CLEAR)
        begin
            used_len = '0;
            queue_char(CHAR_NONE, '0, 1'b1, 1'b1, '0);
        end
        else if (used_len > capacity ||
                 64'(used_len) + 64'(SPACE_NEEDED) > 64'(capacity))
        begin
            queue_char(CHAR_NONE, 16'(used_len), 1'b0, 1'b1, 16'(used_len));
        end
        else
        begin
            // zero falls out as a single digit
            do
            begin
                text.push_front(CHAR_ZERO + 8'(mag % RADIX));
                mag = mag / RADIX;
            end
            while (mag != 0);
            if (neg)
                text.push_front(CHAR_MINUS);
            for (int i = 0; i < text.size(); i++)
            begin
                off      = used_len;
                used_len = used_len + 1'b1;
                queue_char(text[i], 16'(off), 1'b1, i == text.size() - 1, 16'(used_len));
            end
        end
    endfunction

    function automatic void compare_field(string field, longint want, longint got);
        if (want != got)
        begin
            err_count++;
            if (err_count <= 200)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
        end
    endfunction

    function automatic void check_char();
        char_txn_t want;
        char_count++;
        if (expected_chars.size() == 0)
        begin
            err_count++;
            if (err_count <= 200)
                $display("%0t ns: unexpected transaction, expected none, actual data %h last %b",
                         $time, m_tdata, m_tlast);
            return;
        end
        want = expected_chars.pop_front();
        compare_field("text_byte", want.text_byte, m_tdata[7:0]);
        compare_field("byte_offset", want.byte_offset, m_tdata[23:8]);
        compare_field("fill_length", want.fill_length, m_tdata[39:24]);
        compare_field("accepted", want.accepted, m_tuser[0]);
        compare_field("last_of_run", want.last_of_run, m_tlast);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity = CAPACITY_RESET;
            used_len = '0;
            expected_chars.delete();
            pending_count = 0;
        end
        else
        begin
            // writes to any other register index are dropped
            if (psel && penable && pwrite && pready && paddr[2:2] == REG_BUFFER_CAPACITY)
                capacity = pwdata[CAP_BITS-1:0];
            if (m_tvalid && m_tready)
                check_char();
            if (s_tvalid && s_tready)
            begin
                predict_text(s_tuser[0], s_tdata);
                item_count++;
            end
            pending_count = expected_chars.size();
        end
    end

endmodule

### verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import i64dta_pkg::*;

    localparam logic [2:0]  CAPACITY_ADDR = {REG_BUFFER_CAPACITY, 2'b00};
    localparam logic [2:0]  SPARE_ADDR    = 3'd4;
    localparam logic [63:0] MOST_NEG      = 64'h8000_0000_0000_0000;
    localparam logic [63:0] INT64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum int { RX_FREE, RX_HALF, RX_SPARSE, RX_BUSY } rx_mode_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [VALUE_BITS-1:0]    s_tdata = '0;     // number_value[63:0]
    logic [0:0]               s_tuser = OP_APPEND; // opcode[0]
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;          // text_byte[7:0], byte_offset[23:8],
                                                // fill_length[39:24]
    logic [0:0]               m_tuser;          // accepted[0]
    logic                     m_tlast;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [2:0]               paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;

    int       fail_count;
    int       in_flight;
    int       items_done;
    int       results_done;
    int       burst_left = 0;
    rx_mode_t rx_mode = RX_FREE;
    int       mode_left = 0;

    int64_decimal_text_appender u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    decimal_text_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .mismatches   (fail_count),
        .in_flight    (in_flight),
        .items_seen   (items_done),
        .results_seen (results_done)
    );

    always #5 clk = ~clk;

    // receiver back-pressure: switch at random between stall patterns
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            rx_mode   = rx_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (rx_mode)
            RX_FREE:   m_tready <= 1'b1;
            RX_HALF:   m_tready <= ($urandom_range(0, 1) == 0);
            RX_SPARSE: m_tready <= (mode_left % 8 == 0);
            default:   m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_item(input logic op, input logic [63:0] value);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(20, 120)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(0, 8);
        end
    endtask

    // hold the sender until every expected transaction has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        logic [63:0] scale;
        int          k;
        scale = 64'd1;
        k     = $urandom_range(1, 19);
        repeat (k) scale = scale * 10;
        case ($urandom_range(0, 7))
            0, 1, 2: v = {$urandom, $urandom};
            3, 4:    v = {$urandom, $urandom} % scale;
            5:       v = 64'($urandom_range(0, 40)) - 64'd20;
            6:       v = scale - 64'($urandom_range(0, 1));
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       v = MOST_NEG;
                    1:       v = INT64_MAX;
                    2:       v = MOST_NEG + 64'd1;
                    default: v = '0;
                endcase
            end
        endcase
        if ($urandom_range(0, 1) == 1 && v != MOST_NEG)
            v = -v;
        return v;
    endfunction

    task automatic run_random(input int count, input int clear_pct);
        logic op;
        repeat (count)
        begin
            op = ($urandom_range(0, 99) < clear_pct) ? OP_CLEAR : OP_APPEND;
            send_item(op, pick_value());
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_APPEND, 64'd0);
        send_item(OP_APPEND, 64'd1);
        send_item(OP_APPEND, -64'd1);
        send_item(OP_APPEND, 64'd9);
        send_item(OP_APPEND, 64'd10);
        send_item(OP_APPEND, -64'd10);
        send_item(OP_APPEND, INT64_MAX);
        send_item(OP_APPEND, MOST_NEG);
        send_item(OP_APPEND, MOST_NEG + 64'd1);
        send_item(OP_APPEND, 64'd1_000_000_000_000_000_000);
        send_item(OP_APPEND, -64'd999_999_999_999_999_999);
        send_item(OP_CLEAR, {$urandom, $urandom});
        send_item(OP_APPEND, 64'd7);
        drain();

        // an unmapped register index must leave the capacity alone
        cfg_write(SPARE_ADDR, 32'd0);
        send_item(OP_APPEND, 64'd123);
        drain();

        cfg_write(CAPACITY_ADDR, 32'd21);
        send_item(OP_CLEAR, '0);
        send_item(OP_APPEND, 64'd0);
        send_item(OP_APPEND, 64'd5);
        send_item(OP_CLEAR, '1);
        send_item(OP_APPEND, MOST_NEG);
        send_item(OP_APPEND, 64'd3);
        drain();

        cfg_write(CAPACITY_ADDR, 32'd0);
        send_item(OP_APPEND, 64'd42);
        send_item(OP_CLEAR, '0);
        send_item(OP_APPEND, -64'd7);
        drain();

        cfg_write(CAPACITY_ADDR, 32'd65535);
        send_item(OP_APPEND, -64'd123_456_789);
        run_random(50, 5);
        drain();

        cfg_write(CAPACITY_ADDR, $urandom_range(21, 400));
        run_random(35, 20);
        drain();

        cfg_write(CAPACITY_ADDR, 32'(CAPACITY_RESET));
        run_random(35, 10);
        drain();

        cfg_write(CAPACITY_ADDR, $urandom_range(0, 65535));
        run_random(25, 10);
        drain();
        repeat (100) @(posedge clk);

        $display("Run covered %0d input transactions and %0d character transactions,",
                 items_done, results_done);
        $display("with capacities 0 to 65535, sign and zero cases, extreme values and refusals.");
        if (fail_count == 0 && in_flight == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d transactions still outstanding", in_flight);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
